[src/ctbt_pkg.sv]
package ctbt_pkg;

	localparam int DEF_CHANNELS      = 4;
	localparam int DEF_CALIB_SAMPLES = 20;

	localparam int CH_FIELD_W = 2;
	localparam int SAMPLE_W   = 22;
	localparam int STRENGTH_W = 17;
	localparam int SUM_W      = 27;
	localparam int CNT_W      = 5;
	localparam int PERMILLE_W = 10;
	localparam int CFG_W      = 22;
	localparam int CFG_IDX_W  = 1;

	localparam int FACTOR_W = 11;
	localparam int THR_W    = 33;
	localparam int MIX_W    = 32;
	localparam int RECIP_W  = 32;
	localparam int RPROD_W  = 64;
	localparam int RECIP_SHIFT = 41;

	// ceil(2^32 / n) gives an exact floor for a 27-bit sum and n below 32
	localparam int MEAN_SHIFT   = SUM_W + CNT_W;
	localparam int MEAN_RECIP_W = MEAN_SHIFT + 1;
	localparam int MEAN_PROD_W  = SUM_W + MEAN_RECIP_W;

	localparam int DIV_N_W   = 38;
	localparam int DIV_CNT_W = 6;
	localparam int FRAC_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN  = 1'd1;

	localparam logic KIND_CALIB   = 1'b0;
	localparam logic KIND_MEASURE = 1'b1;

	localparam logic [PERMILLE_W-1:0] RESET_PERMILLE = 10'd300;
	localparam logic [SAMPLE_W-1:0]   RESET_MIN_SPAN = 22'd20000;
	localparam logic [SAMPLE_W-1:0]   LOW_MARK_RESET = 22'd100000;
	localparam logic [STRENGTH_W-1:0] FULL_STRENGTH  = 17'd65536;

	localparam logic [FACTOR_W-1:0] PERMILLE_ONE = 11'd1000;
	localparam logic [MIX_W-1:0]    DECAY_KEEP   = 32'd995;
	localparam logic [MIX_W-1:0]    DECAY_ADD    = 32'd5;
	localparam logic [MIX_W-1:0]    SCALE_ONE    = 32'd1000;
	// ceil(2^41 / 1000), exact floor division for any 32-bit numerator
	localparam logic [RECIP_W-1:0]  RECIP_1000   = 32'd2199023256;

	typedef struct packed {
		logic capture;
		logic eval;
		logic recip;
		logic setup;
		logic commit;
	} ctbt_cmd_t;

	typedef struct packed {
		logic measure;
		logic ch_ok;
		logic calib_full;
		logic div_done;
	} ctbt_sts_t;

endpackage

[src/capacitive_touch_baseline_tracker_core.sv]
// measurement request: passes the eval, recip, setup and divide states before commit;
// the divide state waits on the 38-step radix-2 divider that forms the strength quotient
// calibration request that completes averaging: eval, recip (reciprocal multiply), commit
// other calibration requests and requests for an absent channel: eval, then commit
// one request in flight; a finished result waits in the output register
// arst_n resets all channel state, the sticky flag, configuration and control state
module capacitive_touch_baseline_tracker_core import ctbt_pkg::*; #(
	parameter int CHANNELS      = DEF_CHANNELS,
	parameter int CALIB_SAMPLES = DEF_CALIB_SAMPLES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  kind,
	input  logic [CH_FIELD_W-1:0] channel,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  touched,
	output logic                  any_touch,
	output logic [STRENGTH_W-1:0] strength_q16,
	output logic [SAMPLE_W-1:0]   low_seen,
	output logic [SAMPLE_W-1:0]   high_seen,
	output logic [SAMPLE_W-1:0]   baseline_now,
	output logic                  calib_done
);

	ctbt_cmd_t ctrl_cmd;
	ctbt_sts_t dp_sts;

	ctbt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (dp_sts),
		.cmd          (ctrl_cmd)
	);

	ctbt_dp #(
		.CHANNELS      (CHANNELS),
		.CALIB_SAMPLES (CALIB_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.channel      (channel),
		.sample       (sample),
		.cmd          (ctrl_cmd),
		.sts          (dp_sts),
		.touched      (touched),
		.any_touch    (any_touch),
		.strength_q16 (strength_q16),
		.low_seen     (low_seen),
		.high_seen    (high_seen),
		.baseline_now (baseline_now),
		.calib_done   (calib_done)
	);

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.commit |-> !(result_valid && result_stall))
		else $error("result overwritten while stalled");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.commit |=> result_valid)
		else $error("committed result not presented");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("second request taken while one is in flight");

	a_div_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.setup |=> !dp_sts.div_done)
		else $error("divider finished without iterating");

	a_strength_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (strength_q16 <= FULL_STRENGTH))
		else $error("strength beyond full scale");

endmodule

[src/ctbt_div.sv]
module ctbt_div import ctbt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_N_W-1:0]  dividend,
	input  logic [SAMPLE_W-1:0] divisor,
	output logic                done,
	output logic [DIV_N_W-1:0]  quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [SAMPLE_W-1:0]  dsr_q;
	logic [SAMPLE_W:0]    trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_N_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? SAMPLE_W'(trial - {1'b0, dsr_q}) : trial[SAMPLE_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/ctbt_dp.sv]
module ctbt_dp import ctbt_pkg::*; #(
	parameter int CHANNELS      = DEF_CHANNELS,
	parameter int CALIB_SAMPLES = DEF_CALIB_SAMPLES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  kind,
	input  logic [CH_FIELD_W-1:0] channel,
	input  logic [SAMPLE_W-1:0]   sample,
	input  ctbt_cmd_t             cmd,
	output ctbt_sts_t             sts,
	output logic                  touched,
	output logic                  any_touch,
	output logic [STRENGTH_W-1:0] strength_q16,
	output logic [SAMPLE_W-1:0]   low_seen,
	output logic [SAMPLE_W-1:0]   high_seen,
	output logic [SAMPLE_W-1:0]   baseline_now,
	output logic                  calib_done
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = MEAN_RECIP_W'(
		((64'd1 << MEAN_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

	logic [PERMILLE_W-1:0] permille_q;
	logic [SAMPLE_W-1:0]   min_span_q;

	logic [SAMPLE_W-1:0] base_q [CHANNELS];
	logic [SAMPLE_W-1:0] low_q  [CHANNELS];
	logic [SAMPLE_W-1:0] high_q [CHANNELS];
	logic [SUM_W-1:0]    sum_q  [CHANNELS];
	logic [CNT_W-1:0]    cnt_q  [CHANNELS];
	logic                any_q;

	logic                kind_q;
	logic                ok_q;
	logic [CH_W-1:0]     ch_q;
	logic [SAMPLE_W-1:0] sample_q;

	logic [THR_W-1:0]    thr_prod_q;
	logic [MIX_W-1:0]    s_k_q;
	logic [MIX_W-1:0]    mix_q;
	logic [SUM_W-1:0]    sum_new_q;
	logic [CNT_W-1:0]    cnt_new_q;
	logic                full_q;
	logic [SAMPLE_W-1:0] low_new_q;
	logic [SAMPLE_W-1:0] high_new_q;
	logic                gt_q;
	logic                lt_q;
	logic [SAMPLE_W-1:0] recip_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [SAMPLE_W-1:0] b_new_q;

	logic                touched_q;
	logic                any_out_q;
	logic [STRENGTH_W-1:0] strength_q;
	logic [SAMPLE_W-1:0] low_out_q;
	logic [SAMPLE_W-1:0] high_out_q;
	logic [SAMPLE_W-1:0] base_out_q;
	logic                done_out_q;

	logic [SAMPLE_W-1:0] base_cur;
	logic [SAMPLE_W-1:0] low_cur;
	logic [SAMPLE_W-1:0] high_cur;
	logic [SUM_W-1:0]    sum_new;
	logic [CNT_W-1:0]    cnt_new;
	logic                calib_full;
	logic [FACTOR_W-1:0] thr_factor;
	logic [THR_W-1:0]    s_k_plus;
	logic [RPROD_W-1:0]  recip_prod;
	logic [MEAN_PROD_W-1:0] mean_prod;
	logic [SAMPLE_W-1:0] b_new;
	logic [SAMPLE_W-1:0] diff;
	logic [SAMPLE_W-1:0] span;
	logic [SAMPLE_W-1:0] span_floor;
	logic [SAMPLE_W-1:0] div_dsr;
	logic [DIV_N_W-1:0]  div_dvd;
	logic                div_done;
	logic [DIV_N_W-1:0]  div_quo;
	logic [STRENGTH_W-1:0] strength_clamped;

	assign base_cur = base_q[ch_q];
	assign low_cur  = low_q[ch_q];
	assign high_cur = high_q[ch_q];

	assign sum_new    = sum_q[ch_q] + SUM_W'(sample_q);
	assign cnt_new    = cnt_q[ch_q] + CNT_W'(1);
	assign calib_full = (cnt_new >= CNT_W'(CALIB_SAMPLES));
	assign thr_factor = PERMILLE_ONE + FACTOR_W'(permille_q);

	assign s_k_plus   = {1'b0, s_k_q} + THR_W'(SCALE_ONE);
	assign recip_prod = RPROD_W'(mix_q) * RPROD_W'(RECIP_1000);
	assign mean_prod  = MEAN_PROD_W'(sum_new_q) * MEAN_PROD_W'(MEAN_RECIP);

	always_comb begin
		b_new      = lt_q ? recip_q : base_cur;
		diff       = (sample_q > b_new) ? (sample_q - b_new) : '0;
		span       = (high_new_q > b_new) ? (high_new_q - b_new) : '0;
		span_floor = (min_span_q == '0) ? SAMPLE_W'(1) : min_span_q;
		div_dvd    = {diff, {FRAC_W{1'b0}}};
		div_dsr    = (span < span_floor) ? span_floor : span;
	end

	assign strength_clamped = (div_quo > DIV_N_W'(FULL_STRENGTH)) ? FULL_STRENGTH
		: div_quo[STRENGTH_W-1:0];

	ctbt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.setup),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign sts.measure    = (kind_q == KIND_MEASURE);
	assign sts.ch_ok      = ok_q;
	assign sts.calib_full = calib_full;
	assign sts.div_done   = div_done;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			permille_q <= RESET_PERMILLE;
			min_span_q <= RESET_MIN_SPAN;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_THRESHOLD: permille_q <= cfg_data[PERMILLE_W-1:0];
				REG_MIN_SPAN:  min_span_q <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			ok_q     <= (int'(channel) < CHANNELS);
			ch_q     <= CH_W'(channel);
			sample_q <= sample;
		end
		if (cmd.eval) begin
			thr_prod_q <= THR_W'(base_cur) * THR_W'(thr_factor);
			s_k_q      <= MIX_W'(sample_q) * SCALE_ONE;
			mix_q      <= MIX_W'(base_cur) * DECAY_KEEP + MIX_W'(sample_q) * DECAY_ADD;
			sum_new_q  <= sum_new;
			cnt_new_q  <= cnt_new;
			full_q     <= calib_full;
			low_new_q  <= (sample_q < low_cur) ? sample_q : low_cur;
			high_new_q <= (sample_q > high_cur) ? sample_q : high_cur;
		end
		if (cmd.recip) begin
			gt_q    <= (thr_prod_q < THR_W'(s_k_q));
			lt_q    <= (thr_prod_q >= s_k_plus);
			recip_q <= recip_prod[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
			mean_q  <= mean_prod[MEAN_SHIFT+SAMPLE_W-1:MEAN_SHIFT];
		end
		if (cmd.setup) begin
			b_new_q <= b_new;
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				base_q[i] <= '0;
				low_q[i]  <= LOW_MARK_RESET;
				high_q[i] <= '0;
				sum_q[i]  <= '0;
				cnt_q[i]  <= '0;
			end
			any_q <= 1'b0;
		end else if (cmd.commit && ok_q) begin
			if (kind_q == KIND_MEASURE) begin
				low_q[ch_q]  <= low_new_q;
				high_q[ch_q] <= high_new_q;
				base_q[ch_q] <= b_new_q;
				if (gt_q) begin
					any_q <= 1'b1;
				end
			end else if (full_q) begin
				base_q[ch_q] <= mean_q;
				low_q[ch_q]  <= LOW_MARK_RESET;
				high_q[ch_q] <= '0;
				sum_q[ch_q]  <= '0;
				cnt_q[ch_q]  <= '0;
			end else begin
				sum_q[ch_q] <= sum_new_q;
				cnt_q[ch_q] <= cnt_new_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			touched_q  <= 1'b0;
			any_out_q  <= any_q;
			strength_q <= '0;
			low_out_q  <= '0;
			high_out_q <= '0;
			base_out_q <= '0;
			done_out_q <= 1'b0;
			if (ok_q) begin
				if (kind_q == KIND_MEASURE) begin
					touched_q  <= gt_q;
					any_out_q  <= any_q | gt_q;
					strength_q <= strength_clamped;
					low_out_q  <= low_new_q;
					high_out_q <= high_new_q;
					base_out_q <= b_new_q;
				end else if (full_q) begin
					low_out_q  <= LOW_MARK_RESET;
					base_out_q <= mean_q;
					done_out_q <= 1'b1;
				end else begin
					low_out_q  <= low_cur;
					high_out_q <= high_cur;
					base_out_q <= base_cur;
				end
			end
		end
	end

	assign touched      = touched_q;
	assign any_touch    = any_out_q;
	assign strength_q16 = strength_q;
	assign low_seen     = low_out_q;
	assign high_seen    = high_out_q;
	assign baseline_now = base_out_q;
	assign calib_done   = done_out_q;

endmodule

[src/ctbt_ctrl.sv]
module ctbt_ctrl import ctbt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	output logic      result_valid,
	input  logic      result_stall,
	input  ctbt_sts_t sts,
	output ctbt_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EVAL   = 3'd1;
	localparam logic [2:0] ST_RECIP  = 3'd2;
	localparam logic [2:0] ST_SETUP  = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_COMMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (!sts.ch_ok) begin
					state_d = ST_COMMIT;
				end else if (sts.measure || sts.calib_full) begin
					state_d = ST_RECIP;
				end else begin
					state_d = ST_COMMIT;
				end
			end
			ST_RECIP: begin
				cmd.recip = 1'b1;
				if (sts.measure) begin
					state_d = ST_SETUP;
				end else begin
					state_d = ST_COMMIT;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (!out_valid_q || !result_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;

endmodule
